[hw/rtl/kbelt_pkg.sv]
// Shared types, constants and flag functions for the key and button edge tracker.
// Used by kbelt_ctrl, kbelt_datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package kbelt_pkg;

  localparam int KEY_COUNT          = 512;
  localparam int MOUSE_BUTTON_COUNT = 8;
  localparam int KEY_EVENT_LIMIT    = 64;
  localparam int MOUSE_EVENT_LIMIT  = 16;

  localparam int KEY_AW   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int MOUSE_AW = (MOUSE_BUTTON_COUNT > 1) ? $clog2(MOUSE_BUTTON_COUNT) : 1;
  localparam int KEY_CNT_W   = $clog2(KEY_EVENT_LIMIT + 1);
  localparam int MOUSE_CNT_W = $clog2(MOUSE_EVENT_LIMIT + 1);

  typedef enum logic [1:0] {
    ACT_EVENT = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic {
    DEV_KEY   = 1'b0,
    DEV_MOUSE = 1'b1
  } device_t;

  typedef struct packed {
    logic [1:0] action;
    logic       device;
    logic [8:0] code;
    logic       down;
  } cmd_t;

  typedef struct packed {
    logic pressed;
    logic held;
    logic released;
    logic up;
  } result_t;

  // Per-code flag word; cur sits at bit 0.
  typedef struct packed {
    logic plvl;
    logic prel;
    logic pprs;
    logic lrel;
    logic lprs;
    logic prev;
    logic cur;
  } flags_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_KEY_MOD,
    ST_KEY_QRY,
    ST_SWEEP
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic key_rd;
    logic key_stage;
    logic mouse_stage;
    logic sweep_start;
    logic sweep_step;
    logic clear_step;
    logic emit_key;
    logic emit_mouse;
    logic emit_zero;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] action;
    logic       device;
    logic       key_ok;
    logic       mouse_ok;
    logic       key_room;
    logic       mouse_room;
    logic       sweep_last;
  } dp_status_t;

  function automatic flags_t stage_flags(input flags_t f, input logic down);
    flags_t n;
    n = f;
    if (down) begin
      n.pprs = 1'b1;
      n.plvl = 1'b1;
    end else begin
      n.prel = 1'b1;
      n.plvl = 1'b0;
    end
    return n;
  endfunction

  function automatic flags_t commit_flags(input flags_t f);
    flags_t n;
    n      = '0;
    n.prev = f.cur;
    n.cur  = (f.pprs | f.prel) ? f.plvl : f.cur;
    n.lprs = f.pprs;
    n.lrel = f.prel;
    return n;
  endfunction

  function automatic result_t query_flags(input flags_t f);
    result_t r;
    r.pressed  = f.lprs & ~f.prev;
    r.held     = f.cur & f.prev;
    r.released = f.lrel & f.prev;
    r.up       = ~f.cur & ~f.prev;
    return r;
  endfunction

endpackage

[hw/rtl/kbelt_ctrl.sv]
// Controller state machine for the key and button edge tracker.
// Depends on kbelt_pkg; drives kbelt_datapath through ctrl_cmd_t.
`timescale 1ns / 1ps

module kbelt_ctrl
  import kbelt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output ctrl_cmd_t  ctl,
  output logic       busy
);

  ctrl_state_t state, state_next;

  logic key_event_ok;
  logic mouse_event_ok;

  assign key_event_ok   = (status.device == DEV_KEY) && status.key_ok && status.key_room;
  assign mouse_event_ok = (status.device == DEV_MOUSE) && status.mouse_ok && status.mouse_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (action_t'(status.action))
          ACT_EVENT: state_next = key_event_ok ? ST_KEY_MOD : ST_IDLE;
          ACT_TICK:  state_next = ST_SWEEP;
          ACT_QUERY: begin
            state_next = (status.device == DEV_KEY && status.key_ok) ? ST_KEY_QRY : ST_IDLE;
          end
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_KEY_MOD: state_next = ST_IDLE;
      ST_KEY_QRY: state_next = ST_IDLE;
      ST_SWEEP: begin
        if (status.sweep_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    unique case (state)
      ST_CLEAR: ctl.clear_step = 1'b1;
      ST_IDLE: begin
        busy      = 1'b0;
        ctl.latch = start;
      end
      ST_EXEC: begin
        unique case (action_t'(status.action))
          ACT_EVENT: begin
            ctl.key_rd      = key_event_ok;
            ctl.mouse_stage = mouse_event_ok;
          end
          ACT_TICK: ctl.sweep_start = 1'b1;
          ACT_QUERY: begin
            if (status.device == DEV_KEY) begin
              ctl.key_rd    = status.key_ok;
              ctl.emit_zero = ~status.key_ok;
            end else begin
              ctl.emit_mouse = status.mouse_ok;
              ctl.emit_zero  = ~status.mouse_ok;
            end
          end
          default: ;
        endcase
      end
      ST_KEY_MOD: ctl.key_stage  = 1'b1;
      ST_KEY_QRY: ctl.emit_key   = 1'b1;
      ST_SWEEP:   ctl.sweep_step = 1'b1;
      default: ;
    endcase
  end

endmodule

[hw/rtl/kbelt_datapath.sv]
// Datapath of the key and button edge tracker: key flag memory, mouse flag
// registers, event counters, sweep address and the result register. Uses kbelt_pkg.
`timescale 1ns / 1ps

module kbelt_datapath
  import kbelt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  ctrl_cmd_t  ctl,
  output dp_status_t status,
  output result_t    result,
  output logic       done
);

  flags_t key_mem [KEY_COUNT];
  flags_t key_rdata;
  flags_t mouse_flags [MOUSE_BUTTON_COUNT];

  cmd_t                   cmd_q;
  logic [KEY_CNT_W-1:0]   key_events;
  logic [MOUSE_CNT_W-1:0] mouse_events;
  logic [KEY_AW-1:0]      sweep_addr;

  logic [KEY_AW-1:0]   key_idx;
  logic [MOUSE_AW-1:0] mouse_idx;
  logic [KEY_AW-1:0]   rd_addr;
  logic                rd_en;
  logic [KEY_AW-1:0]   wr_addr;
  logic                wr_en;
  flags_t              wr_data;

  assign key_idx   = KEY_AW'(cmd_q.code);
  assign mouse_idx = MOUSE_AW'(cmd_q.code);

  assign status.action     = cmd_q.action;
  assign status.device     = cmd_q.device;
  assign status.key_ok     = 32'(cmd_q.code) < KEY_COUNT;
  assign status.mouse_ok   = 32'(cmd_q.code) < MOUSE_BUTTON_COUNT;
  assign status.key_room   = 32'(key_events) < KEY_EVENT_LIMIT;
  assign status.mouse_room = 32'(mouse_events) < MOUSE_EVENT_LIMIT;
  assign status.sweep_last = sweep_addr == KEY_AW'(KEY_COUNT - 1);

  always_ff @(posedge clk) begin
    if (ctl.latch) cmd_q <= cmd;
  end

  // The sweep reads one entry ahead of the entry it writes back.
  always_comb begin
    rd_en   = ctl.key_rd | ctl.sweep_start | (ctl.sweep_step & ~status.sweep_last);
    rd_addr = key_idx;
    if (ctl.sweep_start) begin
      rd_addr = '0;
    end else if (ctl.sweep_step) begin
      rd_addr = sweep_addr + 1'b1;
    end
    wr_en   = ctl.key_stage | ctl.sweep_step | ctl.clear_step;
    wr_addr = key_idx;
    wr_data = stage_flags(key_rdata, cmd_q.down);
    if (ctl.sweep_step) begin
      wr_addr = sweep_addr;
      wr_data = commit_flags(key_rdata);
    end else if (ctl.clear_step) begin
      wr_addr = sweep_addr;
      wr_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) key_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) key_rdata <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (ctl.sweep_start) begin
      sweep_addr <= '0;
    end else if (ctl.sweep_step || ctl.clear_step) begin
      sweep_addr <= sweep_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_events   <= '0;
      mouse_events <= '0;
    end else if (ctl.sweep_start) begin
      key_events   <= '0;
      mouse_events <= '0;
    end else begin
      if (ctl.key_stage) key_events <= key_events + 1'b1;
      if (ctl.mouse_stage) mouse_events <= mouse_events + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOUSE_BUTTON_COUNT; i++) mouse_flags[i] <= '0;
    end else if (ctl.sweep_start) begin
      for (int i = 0; i < MOUSE_BUTTON_COUNT; i++) mouse_flags[i] <= commit_flags(mouse_flags[i]);
    end else if (ctl.mouse_stage) begin
      mouse_flags[mouse_idx] <= stage_flags(mouse_flags[mouse_idx], cmd_q.down);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.emit_key | ctl.emit_mouse | ctl.emit_zero;
    end
  end

  always_ff @(posedge clk) begin
    priority if (ctl.emit_key) begin
      result <= query_flags(key_rdata);
    end else if (ctl.emit_mouse) begin
      result <= query_flags(mouse_flags[mouse_idx]);
    end else if (ctl.emit_zero) begin
      result <= '0;
    end
  end

endmodule

[hw/rtl/key_button_edge_latch_tracker_core.sv]
// Top level of the key and button edge tracker.
// Instantiates kbelt_ctrl and kbelt_datapath; types come from kbelt_pkg.
`timescale 1ns / 1ps

// A command is taken at a clock edge where start is high and busy is low. A query
// answers with one result on the result port, marked by done for exactly one cycle;
// the receiver has no way to hold it off, so it must take the transfer when done is
// high. Events and ticks give no result. Keyboard events within the event limit and
// in-range keyboard queries keep busy high through ST_EXEC and then ST_KEY_MOD or
// ST_KEY_QRY; all other events and queries, including dropped events and out-of-range
// codes, and the unused action code keep it high for ST_EXEC only. The result strobe
// rises as busy falls. A tick commits the mouse registers at once and walks the
// 512-entry keyboard flag memory one entry per cycle through its single write port,
// keeping busy high through ST_EXEC and the ST_SWEEP pass. After reset the block
// clears all 512 keyboard entries, busy high, before the first transfer.
module key_button_edge_latch_tracker_core
  import kbelt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    cmd,
  output logic    busy,
  output logic    done,
  output result_t result
);

  ctrl_cmd_t  ctl;
  dp_status_t status;

  kbelt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctl    (ctl),
    .busy   (busy)
  );

  kbelt_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .ctl    (ctl),
    .status (status),
    .result (result),
    .done   (done)
  );

  // A transfer always starts work, so the block is busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("busy not raised after an accepted command");

  // A result only follows a cycle of work, never a cycle that was idle.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result strobe without preceding work");

  // The clearing pass keeps commands out right after reset.
  assert property (@(posedge clk) $fell(rst) |-> busy)
    else $error("command port open before the clearing pass");

endmodule

[bench/tb.sv]
// Self-checking testbench for key_button_edge_latch_tracker_core.
// Predicts query answers from its own copy of the key and button flags;
// needs kbelt_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import kbelt_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int MAX_GAP     = 40;
  localparam int CMD_W       = $bits(cmd_t);

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    done;
  result_t result;

  key_button_edge_latch_tracker_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always #6 clk = ~clk;

  // Tracked copy of the flag stores and the per-tick event counters.
  flags_t  key_state [KEY_COUNT];
  flags_t  btn_state [MOUSE_BUTTON_COUNT];
  int      key_ev_count;
  int      btn_ev_count;
  result_t answer_q [$];

  int          fail_count = 0;
  int          idle_pct = 0;
  int unsigned cycle_count = 0;
  result_t     want;
  string       field_name [4] = '{"up", "released", "held", "pressed"};

  function automatic flags_t staged(flags_t f, logic down);
    flags_t n;
    n = f;
    if (down) begin
      n.pprs = 1'b1;
    end else begin
      n.prel = 1'b1;
    end
    n.plvl = down;
    return n;
  endfunction

  // The tick turns pending marks into latched flags and shifts the level.
  function automatic flags_t committed(flags_t f);
    flags_t n;
    n      = '0;
    n.prev = f.cur;
    if (f.pprs || f.prel) begin
      n.cur = f.plvl;
    end else begin
      n.cur = f.cur;
    end
    n.lprs = f.pprs;
    n.lrel = f.prel;
    return n;
  endfunction

  function automatic result_t answer_for(flags_t f, bit in_range);
    result_t r;
    r = '0;
    if (in_range) begin
      r.pressed  = f.lprs && !f.prev;
      r.held     = f.cur && f.prev;
      r.released = f.lrel && f.prev;
      r.up       = !f.cur && !f.prev;
    end
    return r;
  endfunction

  task automatic track_cmd(input cmd_t c);
    bit key_ok;
    bit btn_ok;
    key_ok = c.code < KEY_COUNT;
    btn_ok = c.code < MOUSE_BUTTON_COUNT;
    case (action_t'(c.action))
      ACT_EVENT: begin
        if (device_t'(c.device) == DEV_KEY) begin
          if (key_ok && key_ev_count < KEY_EVENT_LIMIT) begin
            key_ev_count++;
            key_state[c.code] = staged(key_state[c.code], c.down);
          end
        end else if (btn_ok && btn_ev_count < MOUSE_EVENT_LIMIT) begin
          btn_ev_count++;
          btn_state[c.code] = staged(btn_state[c.code], c.down);
        end
      end
      ACT_TICK: begin
        foreach (key_state[i]) key_state[i] = committed(key_state[i]);
        foreach (btn_state[i]) btn_state[i] = committed(btn_state[i]);
        key_ev_count = 0;
        btn_ev_count = 0;
      end
      ACT_QUERY: begin
        if (device_t'(c.device) == DEV_KEY) begin
          answer_q.push_back(answer_for(key_ok ? key_state[c.code] : '0, key_ok));
        end else begin
          answer_q.push_back(answer_for(btn_ok ? btn_state[c.code] : '0, btn_ok));
        end
      end
      default: ;
    endcase
  endtask

  // Drives one command until the core takes it, then idles at random.
  task automatic send_cmd(input action_t act, input device_t dev,
                          input logic [8:0] code, input logic down);
    cmd_t c;
    int   gap;
    c.action = act;
    c.device = dev;
    c.code   = code;
    c.down   = down;
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    track_cmd(c);
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      cmd   <= cmd_t'(CMD_W'($urandom));
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_tick();
    send_cmd(ACT_TICK, device_t'($urandom_range(1)), 9'($urandom_range(511)),
             1'($urandom_range(1)));
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Every strobed result is matched against the oldest pending query.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (answer_q.size() == 0) begin
        $display("%0t: result with no query pending, expected none, actual %b",
                 $time, result);
        fail_count++;
      end else begin
        want = answer_q.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (want[i] !== result[i]) begin
            $display("%0t: %s mismatch, expected %b, actual %b",
                     $time, field_name[i], want[i], result[i]);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic test_reset_state();
    send_cmd(ACT_QUERY, DEV_KEY, 9'd0, 1'b0);
    send_cmd(ACT_QUERY, DEV_MOUSE, 9'd7, 1'b1);
  endtask

  task automatic test_edges();
    send_cmd(ACT_EVENT, DEV_KEY, 9'd0, 1'b1);
    send_cmd(ACT_EVENT, DEV_KEY, 9'd511, 1'b1);
    send_cmd(ACT_EVENT, DEV_KEY, 9'd300, 1'b1);
    send_cmd(ACT_EVENT, DEV_KEY, 9'd300, 1'b0);
    send_cmd(ACT_EVENT, DEV_MOUSE, 9'd7, 1'b1);
    send_cmd(ACT_EVENT, DEV_MOUSE, 9'd0, 1'b0);
    send_cmd(ACT_TICK, DEV_MOUSE, 9'd511, 1'b1);
    send_cmd(ACT_QUERY, DEV_KEY, 9'd0, 1'b0);
    send_cmd(ACT_QUERY, DEV_KEY, 9'd511, 1'b0);
    send_cmd(ACT_QUERY, DEV_KEY, 9'd300, 1'b0);
    send_cmd(ACT_QUERY, DEV_MOUSE, 9'd7, 1'b0);
    // With no new events the press turns into a hold; a release event then gives a release.
    send_cmd(ACT_TICK, DEV_KEY, 9'd0, 1'b0);
    send_cmd(ACT_QUERY, DEV_KEY, 9'd0, 1'b1);
    send_cmd(ACT_EVENT, DEV_KEY, 9'd0, 1'b0);
    send_cmd(ACT_TICK, DEV_KEY, 9'd0, 1'b0);
    send_cmd(ACT_QUERY, DEV_KEY, 9'd0, 1'b0);
  endtask

  task automatic test_out_of_range();
    send_cmd(ACT_EVENT, DEV_MOUSE, 9'd8, 1'b1);
    send_cmd(ACT_EVENT, DEV_MOUSE, 9'd511, 1'b1);
    send_cmd(ACT_NONE, DEV_KEY, 9'd5, 1'b1);
    send_cmd(ACT_TICK, DEV_MOUSE, 9'd0, 1'b0);
    send_cmd(ACT_QUERY, DEV_MOUSE, 9'd8, 1'b0);
    send_cmd(ACT_QUERY, DEV_MOUSE, 9'd511, 1'b1);
    send_cmd(ACT_QUERY, DEV_KEY, 9'd5, 1'b0);
  endtask

  // Rounds of events on a few active codes, usually a tick, then queries of those codes.
  // Some rounds are long bursts that run a device into its event limit.
  task automatic test_random_traffic(input int n_items, input int pct);
    int         sent;
    int         n_ev;
    int         mouse_share;
    int         r;
    logic [8:0] hot_key [4];
    logic [8:0] hot_btn [3];
    idle_pct = pct;
    sent = 0;
    while (sent < n_items) begin
      foreach (hot_key[i]) hot_key[i] = 9'($urandom_range(511));
      foreach (hot_btn[i]) hot_btn[i] = 9'($urandom_range(MOUSE_BUTTON_COUNT - 1));
      case ($urandom_range(2))
        0: mouse_share = 10;
        1: mouse_share = 50;
        default: mouse_share = 90;
      endcase
      n_ev = ($urandom_range(7) == 0) ? $urandom_range(20, 75) : $urandom_range(12);
      repeat (n_ev) begin
        r = $urandom_range(99);
        if (r < 8) begin
          send_cmd(ACT_EVENT, device_t'($urandom_range(1)), 9'($urandom_range(511)),
                   1'($urandom_range(1)));
        end else if (r < 11) begin
          send_cmd(ACT_QUERY, device_t'($urandom_range(1)), 9'($urandom_range(511)),
                   1'($urandom_range(1)));
        end else if (r < 13) begin
          send_cmd(ACT_NONE, device_t'($urandom_range(1)), 9'($urandom_range(511)),
                   1'($urandom_range(1)));
        end else if ($urandom_range(99) < mouse_share) begin
          send_cmd(ACT_EVENT, DEV_MOUSE, hot_btn[$urandom_range(2)], 1'($urandom_range(1)));
        end else begin
          send_cmd(ACT_EVENT, DEV_KEY, hot_key[$urandom_range(3)], 1'($urandom_range(1)));
        end
      end
      sent += n_ev;
      if ($urandom_range(9) != 0) begin
        send_tick();
        sent++;
      end
      foreach (hot_key[i]) send_cmd(ACT_QUERY, DEV_KEY, hot_key[i], 1'($urandom_range(1)));
      foreach (hot_btn[i]) send_cmd(ACT_QUERY, DEV_MOUSE, hot_btn[i], 1'($urandom_range(1)));
      send_cmd(ACT_QUERY, device_t'($urandom_range(1)), 9'($urandom_range(511)),
               1'($urandom_range(1)));
      sent += 8;
    end
  endtask

  initial begin
    foreach (key_state[i]) key_state[i] = '0;
    foreach (btn_state[i]) btn_state[i] = '0;
    key_ev_count = 0;
    btn_ev_count = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_edges();
    test_out_of_range();
    test_random_traffic(200, 0);
    test_random_traffic(150, 80);
    test_random_traffic(200, 29);
    test_random_traffic(150, 0);
    start <= 1'b0;

    while (answer_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && answer_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
